FILE: src/assert_macros.svh
// Assertion macros for the RTL files; the deframer core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cld_pkg.sv
// Types, codes and the header prefix table of the content-length deframer.
package cld_pkg;

    localparam int unsigned DEF_LENGTH_BITS = 32;
    localparam int unsigned CFG_WIDTH       = 32;
    localparam logic [CFG_WIDTH-1:0] MAX_LEN_RESET = '1;

    localparam logic [3:0] PREFIX_LEN = 4'd15;

    // frame_status codes
    localparam logic [2:0] ST_PAYLOAD = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_MISSING = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_LARGE   = 3'd4;

    // pending header error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_INVALID = 2'd1;
    localparam logic [1:0] ERR_LARGE   = 2'd2;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'b01,
        PH_PAYLOAD = 2'b10
    } phase_t;

    typedef enum logic [2:0] {
        LF_PREFIX = 3'b001,
        LF_IGNORE = 3'b010,
        LF_VALUE  = 3'b100
    } line_field_t;

    // "Content-Length:" one character per index
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

endpackage

FILE: src/content_length_deframer_core.sv
// Content-Length header parser and payload forwarder for a byte stream.
//
//   port group | dir | tdata          | tuser        | tlast
//   s_*        | in  | in_byte        | -            | -
//   m_*        | out | out_byte       | frame_status | end_of_frame
//   cfg_*      | in  | max_payload_length (write only)
//
// One word per clock is taken while s_tready is high and parsed in the cycle it
// is accepted. Its result is registered in the output register, or in the skid
// stage behind it, which takes one word while m_tready is low. Header bytes give
// no result but the final LF of CR LF CR LF on an empty or bad header. s_tready
// drops only while the skid stage is full and rises again the cycle after a pop.
// Reset is synchronous, active low; max_payload_length resets to all ones.
`include "assert_macros.svh"

module content_length_deframer_core #(
    parameter int unsigned LENGTH_BITS = cld_pkg::DEF_LENGTH_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,     // [7:0] in_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,     // [7:0] out_byte
    output logic [2:0]                     m_tuser,     // [2:0] frame_status
    output logic                           m_tlast,     // end_of_frame
    input  logic                           cfg_wr_en,
    input  logic [cld_pkg::CFG_WIDTH-1:0]  cfg_wr_data  // max_payload_length
);
    import cld_pkg::*;

    localparam int unsigned LB = LENGTH_BITS;
    localparam int unsigned CW = (LENGTH_BITS > CFG_WIDTH) ? LENGTH_BITS : CFG_WIDTH;

    // parser state
    phase_t           phase_reg, phase_next;
    logic [1:0]       term_reg, term_next;
    line_field_t      lf_reg, lf_next;
    logic [3:0]       pidx_reg, pidx_next;
    logic [LB-1:0]    acc_reg, acc_next;
    logic             found_reg, found_next;
    logic             digit_reg, digit_next;
    logic [1:0]       perr_reg, perr_next;
    logic [LB-1:0]    rem_reg, rem_next;
    logic [CFG_WIDTH-1:0] max_len_reg;

    // output register and skid stage
    logic             out_valid_reg, skid_valid_reg;
    logic [7:0]       out_byte_reg, skid_byte_reg;
    logic [2:0]       out_status_reg, skid_status_reg;
    logic             out_last_reg, skid_last_reg;

    logic             accept, pop;
    logic             res_valid, res_last;
    logic [7:0]       res_byte;
    logic [2:0]       res_status;
    logic             hdr_clear, go_payload;
    logic [1:0]       perr_end;

    logic             is_digit;
    logic [LB+3:0]    prod;
    logic             ovf;
    logic             too_large;

    assign s_tready = ~skid_valid_reg;
    assign accept   = s_tvalid & s_tready;
    assign pop      = out_valid_reg & m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    assign is_digit = (s_tdata >= "0") && (s_tdata <= "9");
    // acc * 10 + digit, top four bits flag overflow of LB bits
    assign prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                + {{LB{1'b0}}, s_tdata[3:0]};
    assign ovf  = |prod[LB+3:LB];
    assign too_large = CW'(acc_reg) > CW'(max_len_reg);

    always_comb begin
        phase_next = phase_reg;
        term_next  = term_reg;
        lf_next    = lf_reg;
        pidx_next  = pidx_reg;
        acc_next   = acc_reg;
        found_next = found_reg;
        digit_next = digit_reg;
        perr_next  = perr_reg;
        rem_next   = rem_reg;
        res_valid  = 1'b0;
        res_byte   = 8'h00;
        res_status = ST_PAYLOAD;
        res_last   = 1'b0;
        hdr_clear  = 1'b0;
        go_payload = 1'b0;
        perr_end   = perr_reg;

        if (accept) begin
            if (phase_reg == PH_PAYLOAD) begin
                res_valid = 1'b1;
                res_byte  = s_tdata;
                res_last  = (rem_reg <= LB'(1));
                if (res_last) begin
                    hdr_clear = 1'b1;
                end else begin
                    rem_next = rem_reg - LB'(1);
                end
            end else if ((s_tdata == CHAR_LF) && term_reg[0]) begin
                // line end; term_reg odd means CR seen (1 or 3)
                if ((lf_reg == LF_VALUE) && !digit_reg && (perr_reg == ERR_NONE)) begin
                    perr_end = ERR_INVALID;
                end
                lf_next    = LF_PREFIX;
                pidx_next  = '0;
                digit_next = 1'b0;
                if (term_reg == 2'd3) begin
                    hdr_clear = 1'b1;
                    priority if (perr_end == ERR_INVALID) begin
                        res_status = ST_INVALID;
                    end else if (perr_end == ERR_LARGE) begin
                        res_status = ST_LARGE;
                    end else if (!found_reg) begin
                        res_status = ST_MISSING;
                    end else if (too_large) begin
                        res_status = ST_LARGE;
                    end else if (acc_reg == '0) begin
                        res_status = ST_EMPTY;
                    end else begin
                        go_payload = 1'b1;
                    end
                    res_valid = ~go_payload;
                    res_last  = 1'b1;
                end else begin
                    term_next = 2'd2;
                    perr_next = perr_end;
                end
            end else begin
                unique case (lf_reg)
                    LF_PREFIX: begin
                        if (s_tdata == prefix_char(pidx_reg)) begin
                            pidx_next = pidx_reg + 4'd1;
                            if (pidx_reg == PREFIX_LEN - 4'd1) begin
                                lf_next = LF_VALUE;
                            end
                        end else begin
                            lf_next = LF_IGNORE;
                        end
                    end
                    LF_VALUE: begin
                        if (!digit_reg) begin
                            if (is_digit) begin
                                digit_next = 1'b1;
                                acc_next   = LB'(s_tdata[3:0]);
                            end else if (!is_space(s_tdata)) begin
                                if (perr_reg == ERR_NONE) begin
                                    perr_next = ERR_INVALID;
                                end
                                lf_next = LF_IGNORE;
                            end
                        end else if (is_digit) begin
                            if (ovf) begin
                                if (perr_reg == ERR_NONE) begin
                                    perr_next = ERR_LARGE;
                                end
                                lf_next = LF_IGNORE;
                            end else begin
                                acc_next = prod[LB-1:0];
                            end
                        end else begin
                            found_next = 1'b1;
                            lf_next    = LF_IGNORE;
                        end
                    end
                    LF_IGNORE: begin
                    end
                    default: begin
                    end
                endcase
                if (s_tdata == CHAR_CR) begin
                    term_next = (term_reg == 2'd2) ? 2'd3 : 2'd1;
                end else begin
                    term_next = 2'd0;
                end
            end

            if (hdr_clear) begin
                phase_next = go_payload ? PH_PAYLOAD : PH_HEADER;
                rem_next   = go_payload ? acc_reg : '0;
                term_next  = 2'd0;
                lf_next    = LF_PREFIX;
                pidx_next  = '0;
                acc_next   = '0;
                found_next = 1'b0;
                digit_next = 1'b0;
                perr_next  = ERR_NONE;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            term_reg       <= 2'd0;
            lf_reg         <= LF_PREFIX;
            pidx_reg       <= '0;
            acc_reg        <= '0;
            found_reg      <= 1'b0;
            digit_reg      <= 1'b0;
            perr_reg       <= ERR_NONE;
            rem_reg        <= '0;
            max_len_reg    <= MAX_LEN_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            term_reg  <= term_next;
            lf_reg    <= lf_next;
            pidx_reg  <= pidx_next;
            acc_reg   <= acc_next;
            found_reg <= found_next;
            digit_reg <= digit_next;
            perr_reg  <= perr_next;
            rem_reg   <= rem_next;
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
            if (skid_valid_reg) begin
                if (pop) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (res_valid) begin
                if (out_valid_reg && !m_tready) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result words
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_byte_reg   <= skid_byte_reg;
                out_status_reg <= skid_status_reg;
                out_last_reg   <= skid_last_reg;
            end
        end else if (res_valid) begin
            if (out_valid_reg && !m_tready) begin
                skid_byte_reg   <= res_byte;
                skid_status_reg <= res_status;
                skid_last_reg   <= res_last;
            end else begin
                out_byte_reg   <= res_byte;
                out_status_reg <= res_status;
                out_last_reg   <= res_last;
            end
        end
    end

    `ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with empty output")
    `ASSERT_IMPL(a_status_ends_frame, m_tvalid && (m_tuser != ST_PAYLOAD), m_tlast && (m_tdata == 8'h00), "status word malformed")
    `ASSERT_IMPL(a_payload_count, phase_reg == PH_PAYLOAD, rem_reg != '0, "payload phase with zero count")
    `ASSERT_NEXT(a_last_back_to_header, accept && (phase_reg == PH_PAYLOAD) && (rem_reg <= LB'(1)), phase_reg == PH_HEADER, "no return to header after last byte")

endmodule

FILE: test/tb_content_length_deframer_core.sv
// Self-checking stream testbench for the content-length deframer core.
`timescale 1ns / 1ps

module tb_content_length_deframer_core;
    import cld_pkg::*;

    localparam logic [8*15-1:0] CL_TAG  = "Content-Length:";
    localparam logic [63:0]     LEN_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam int unsigned     RUN_LIMIT = 300000;

    typedef struct {
        logic [7:0] data;
        logic [2:0] status;
        logic       last;
    } out_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = 32'h0;

    content_length_deframer_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // parser mirror
    phase_t      ph;
    logic [1:0]  crlf_run;
    line_field_t field_mode;
    logic [3:0]  match_pos;
    logic [63:0] len_acc;
    logic        len_seen;
    logic        digits_started;
    logic [1:0]  hdr_err;
    logic [63:0] bytes_left;
    logic [31:0] len_limit;

    out_word_t   out_words_due[$];
    logic [7:0]  stream_bytes[$];

    int unsigned words_in = 0;
    int unsigned bytes_queued = 0;
    int unsigned mismatches = 0;
    int unsigned payload_words = 0;
    int unsigned frames_done = 0;
    int unsigned empty_frames = 0;
    int unsigned header_errors = 0;
    int unsigned limits_used = 1;
    int unsigned cyc = 0;
    int unsigned hold_left = 0;
    logic        long_hold_done = 1'b0;
    logic        s_fired = 1'b0;
    logic [31:0] limit_now = 32'hFFFF_FFFF;
    logic        quiet;

    assign quiet = (words_in >= 550) && (words_in < 800);

    task automatic restart_header();
        ph             = PH_HEADER;
        crlf_run       = 2'd0;
        field_mode     = LF_PREFIX;
        match_pos      = 4'd0;
        digits_started = 1'b0;
        len_acc        = 64'd0;
        len_seen       = 1'b0;
        hdr_err        = ERR_NONE;
        bytes_left     = 64'd0;
    endtask

    task automatic flag_error(input logic [1:0] e);
        if (hdr_err == ERR_NONE)
            hdr_err = e;
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        out_word_t   w;
        logic [63:0] d;
        logic [2:0]  st;
        logic        dig;
        logic        blank;
        if (ph == PH_PAYLOAD) begin
            w.data   = b;
            w.status = ST_PAYLOAD;
            w.last   = (bytes_left <= 64'd1);
            out_words_due.push_back(w);
            if (w.last)
                restart_header();
            else
                bytes_left--;
        end else if (b == CHAR_LF && (crlf_run == 2'd1 || crlf_run == 2'd3)) begin
            if (field_mode == LF_VALUE && !digits_started)
                flag_error(ERR_INVALID);
            field_mode     = LF_PREFIX;
            match_pos      = 4'd0;
            digits_started = 1'b0;
            if (crlf_run == 2'd3) begin
                // header done: decide between a payload and a single status word
                if (hdr_err == ERR_INVALID)
                    st = ST_INVALID;
                else if (hdr_err == ERR_LARGE)
                    st = ST_LARGE;
                else if (!len_seen)
                    st = ST_MISSING;
                else if (len_acc > {32'd0, len_limit})
                    st = ST_LARGE;
                else if (len_acc == 64'd0)
                    st = ST_EMPTY;
                else
                    st = ST_PAYLOAD;
                d = len_acc;
                restart_header();
                if (st == ST_PAYLOAD) begin
                    ph         = PH_PAYLOAD;
                    bytes_left = d;
                end else begin
                    w.data   = 8'h00;
                    w.status = st;
                    w.last   = 1'b1;
                    out_words_due.push_back(w);
                end
            end else begin
                crlf_run = 2'd2;
            end
        end else begin
            dig   = (b >= 8'h30) && (b <= 8'h39);
            blank = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
            case (field_mode)
                LF_PREFIX: begin
                    if (match_pos < 4'd15 && b == CL_TAG[8*(14-int'(match_pos)) +: 8]) begin
                        match_pos++;
                        if (match_pos == 4'd15)
                            field_mode = LF_VALUE;
                    end else begin
                        field_mode = LF_IGNORE;
                    end
                end
                LF_VALUE: begin
                    if (dig) begin
                        if (!digits_started) begin
                            digits_started = 1'b1;
                            len_acc        = 64'd0;
                        end
                        d = {56'd0, b} - 64'd48;
                        if (len_acc > (LEN_MAX - d) / 64'd10) begin
                            flag_error(ERR_LARGE);
                            field_mode = LF_IGNORE;
                        end else begin
                            len_acc = len_acc * 64'd10 + d;
                        end
                    end else if (digits_started) begin
                        len_seen   = 1'b1;
                        field_mode = LF_IGNORE;
                    end else if (!blank) begin
                        flag_error(ERR_INVALID);
                        field_mode = LF_IGNORE;
                    end
                end
                default: ;
            endcase
            if (b == CHAR_CR)
                crlf_run = (crlf_run == 2'd2) ? 2'd3 : 2'd1;
            else
                crlf_run = 2'd0;
        end
    endtask

    // check, config shadow and prediction all on the rising edge
    always @(posedge aclk) begin
        out_word_t w;
        s_fired = s_tvalid && s_tready;
        if (!aresetn) begin
            restart_header();
            len_limit = MAX_LEN_RESET;
        end else begin
            if (m_tvalid && m_tready) begin
                if (out_words_due.size() == 0) begin
                    $display("%0t: unexpected word data=%h status=%0d last=%b",
                             $time, m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end else begin
                    w = out_words_due.pop_front();
                    if (m_tdata !== w.data || m_tuser !== w.status || m_tlast !== w.last) begin
                        $display({"%0t: mismatch expected data=%h status=%0d last=%b,",
                                  " got data=%h status=%0d last=%b"},
                                 $time, w.data, w.status, w.last, m_tdata, m_tuser, m_tlast);
                        mismatches++;
                    end
                end
                if (m_tuser == ST_PAYLOAD) begin
                    payload_words++;
                    if (m_tlast)
                        frames_done++;
                end else if (m_tuser == ST_EMPTY) begin
                    empty_frames++;
                end else begin
                    header_errors++;
                end
            end
            if (cfg_wr_en)
                len_limit = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata);
                words_in++;
            end
        end
    end

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fired) begin
            if (stream_bytes.size() != 0 && (quiet || $urandom_range(0, 99) >= 9)) begin
                s_tdata  <= stream_bytes.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && words_in >= 350) begin
            m_tready       <= 1'b0;
            hold_left      <= 300;
            long_hold_done <= 1'b1;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= 9);
        end
    end

    always @(posedge aclk) begin
        cyc++;
        if (cyc > RUN_LIMIT) begin
            $display("%0t: timeout, %0d words still expected", $time, out_words_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        stream_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_payload(input int unsigned n);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        while (stream_bytes.size() != 0 || s_tvalid || out_words_due.size() != 0)
            @(posedge aclk);
        // a header byte may still be in the pipe
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        drain();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        limit_now = v;
        limits_used++;
    endtask

    function automatic string pad_text();
        case ($urandom_range(0, 8))
            0: return "";
            1: return " ";
            2: return "  ";
            3: return "\t";
            4: return " \t";
            5: return "\013";
            6: return "\014";
            7: return "\n";
            default: return "\r ";
        endcase
    endfunction

    function automatic string tail_text();
        case ($urandom_range(0, 5))
            0: return " ";
            1: return ";x";
            2: return "abc";
            default: return "";
        endcase
    endfunction

    function automatic string filler_line();
        string s;
        case ($urandom_range(0, 4))
            0: s = "Content-Type: text\r\n";
            1: s = "content-length: 7\r\n";
            2: s = "Content-Lengt: 3\r\n";
            3: s = "a\rb\r\n";
            default: begin
                s = "X-Id: ";
                repeat ($urandom_range(1, 6))
                    s = {s, $sformatf("%c", 8'($urandom_range(97, 122)))};
                s = {s, "\r\n"};
            end
        endcase
        return s;
    endfunction

    function automatic string bad_value();
        case ($urandom_range(0, 7))
            0: return "";
            1: return " ";
            2: return "+5";
            3: return "-1";
            4: return "x";
            5: return "4294967296";
            6: return "18446744073709551615";
            default: return ".5";
        endcase
    endfunction

    function automatic logic [31:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'd0;
        if (r < 80)
            return $urandom_range(1, 8);
        if (r < 88 && limit_now <= 32'd40)
            return limit_now + $urandom_range(0, 1);
        if (r < 95)
            return $urandom_range(9, 30);
        if (limit_now < 32'h8000_0000)
            return $urandom() | 32'h8000_0000;
        return $urandom_range(1, 8);
    endfunction

    task automatic good_message();
        string       h;
        logic [31:0] n;
        n = pick_length();
        h = "";
        repeat ($urandom_range(0, 2)) h = {h, filler_line()};
        // an earlier length line that the later one overrides
        if ($urandom_range(0, 5) == 0)
            h = {h, "Content-Length: ", $sformatf("%0d", $urandom_range(0, 999)), "\r\n"};
        h = {h, "Content-Length:", pad_text(), $sformatf("%0d", n), tail_text(), "\r\n"};
        if ($urandom_range(0, 3) == 0)
            h = {h, filler_line()};
        push_text({h, "\r\n"});
        if (n != 0 && n <= limit_now)
            push_payload(n);
    endtask

    task automatic bad_message();
        string h;
        case ($urandom_range(0, 5))
            0: begin
                h = "";
                repeat ($urandom_range(0, 2)) h = {h, filler_line()};
                push_text({h, "\r\n"});
            end
            1: push_text({"Content-Length:", pad_text(), bad_value(), "\r\n\r\n"});
            2: push_text({"Content-Length:", bad_value(), "\r\nContent-Length: 3\r\n\r\n"});
            3: push_text({"Content-Length: 3\r\nContent-Length:", bad_value(), "\r\n\r\n"});
            4: begin
                h = $sformatf("%0d", $urandom_range(1, 9));
                repeat ($urandom_range(10, 19)) h = {h, $sformatf("%0d", $urandom_range(0, 9))};
                push_text({"Content-Length: ", h, "\r\n\r\n"});
            end
            default: push_text("content-length: 4\r\n\r\n");
        endcase
    endtask

    task automatic random_traffic(input int unsigned budget);
        int unsigned start;
        int unsigned r;
        start = bytes_queued;
        while (bytes_queued - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                good_message();
            end else if (r < 90) begin
                bad_message();
            end else begin
                repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
                push_text("\r\n\r\n");
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed headers under the reset limit
        push_text("Content-Length: 3\r\n\r\n");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h0A);
        push_text("Content-Length:0\r\n\r\n");
        push_text("\r\n\r\n");
        push_text("\r\r\n\r\n");
        push_text("Content-Length: \r\n\r\n");
        push_text("Content-Length: +5\r\n\r\n");
        push_text("Content-Length: 2xyz\r\n\r\n");
        push_payload(2);
        push_text("Content-Length: 4294967296\r\n\r\n");
        push_text("Content-Length: x\r\nContent-Length: 4\r\n\r\n");
        push_text("Content-Length: 99999999999\r\nContent-Length: x\r\n\r\n");
        push_text("Content-Length: 9\r\nContent-Length: 1\r\n\r\n");
        push_payload(1);
        push_text("Content-Type: a\rb\r\nContent-Length:\t2\r\n\r\n");
        push_payload(2);
        push_text("content-length: 2\r\n\r\n");
        push_text("Content-Length: 1\n\r\n\r\n");
        push_payload(1);
        random_traffic(130);

        write_limit(32'd0);
        push_text("Content-Length: 1\r\n\r\n");
        push_text("Content-Length: 0\r\n\r\n");
        push_text("Content-Length: 4294967295\r\n\r\n");
        random_traffic(80);

        write_limit($urandom_range(3, 12));
        random_traffic(130);

        write_limit($urandom_range(13, 100000));
        random_traffic(70);

        write_limit(32'hFFFF_FFFF);
        random_traffic(90);

        drain();
        repeat (12) @(posedge aclk);
        if (out_words_due.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, out_words_due.size());
            mismatches++;
        end
        $display("Sent %0d stream bytes under %0d length limits;",
                 words_in, limits_used);
        $display("got %0d payload words in %0d frames, %0d empty frames, %0d header errors",
                 payload_words, frames_done, empty_frames, header_errors);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
